// ----- hdl/spt_pkg.sv -----
// ----------------------------------------------------------------------------
// spt_pkg: shared definitions for the sparse polynomial term table
// Table size, field widths, operation and status codes, and the command and
// status bundles that join the controller to the datapath.
// ----------------------------------------------------------------------------
package spt_pkg;

  localparam int MAX_TERMS = 16;
  localparam int IDX_W     = $clog2(MAX_TERMS);
  localparam int CNT_W     = $clog2(MAX_TERMS + 1);
  localparam int POS_W     = (CNT_W > 5) ? CNT_W : 5;
  localparam int EXP_W     = 10;
  localparam int COEF_W    = 32;
  localparam int GRP_SIZE  = 4;
  localparam int NUM_GRP   = (MAX_TERMS + GRP_SIZE - 1) / GRP_SIZE;

  localparam logic [2:0] MODE_ADD    = 3'd0;
  localparam logic [2:0] MODE_SUB    = 3'd1;
  localparam logic [2:0] MODE_PROD   = 3'd2;
  localparam logic [2:0] MODE_SET    = 3'd3;
  localparam logic [2:0] MODE_RD_EXP = 3'd4;
  localparam logic [2:0] MODE_RD_POS = 3'd5;

  localparam logic [2:0] STAT_OK        = 3'd0;
  localparam logic [2:0] STAT_FULL      = 3'd1;
  localparam logic [2:0] STAT_NOT_FOUND = 3'd2;
  localparam logic [2:0] STAT_EMPTY     = 3'd3;
  localparam logic [2:0] STAT_EXP_OVF   = 3'd4;

  typedef struct packed {
    logic load_in;
    logic look;
    logic exec;
    logic deg;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic out_free;
  } sts_t;

endpackage

// ----- hdl/spt_ctrl.sv -----
// ----------------------------------------------------------------------------
// spt_ctrl: operation sequencer
// Steps each item through lookup, execute, degree and result load.
// ----------------------------------------------------------------------------
module spt_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  spt_pkg::sts_t sts,
  output spt_pkg::cmd_t cmd
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_LOOK = 3'd1;
  localparam logic [2:0] S_EXEC = 3'd2;
  localparam logic [2:0] S_DEG  = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_next  = S_LOOK;
        end
      end
      S_LOOK: begin
        cmd.look   = 1'b1;
        state_next = S_EXEC;
      end
      S_EXEC: begin
        cmd.exec   = 1'b1;
        state_next = S_DEG;
      end
      S_DEG: begin
        cmd.deg    = 1'b1;
        state_next = S_DONE;
      end
      S_DONE: begin
        // hold until the result register is free
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// ----- hdl/spt_dp.sv -----
// ----------------------------------------------------------------------------
// spt_dp: term table datapath
// Term registers, parallel exponent match, saturating accumulate, removal
// with compaction, two-level degree tree and the result register.
// ----------------------------------------------------------------------------
module spt_dp (
  input  logic                             clk,
  input  logic                             rst,
  input  spt_pkg::cmd_t                    cmd,
  output spt_pkg::sts_t                    sts,
  input  logic [2:0]                       mode,
  input  logic signed [15:0]               coef_a,
  input  logic [9:0]                       exp_a,
  input  logic signed [15:0]               coef_b,
  input  logic [9:0]                       exp_b,
  input  logic [4:0]                       position,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic signed [31:0]               coefficient,
  output logic [9:0]                       exponent,
  output logic [4:0]                       term_count,
  output logic [9:0]                       degree,
  output logic [2:0]                       status
);

  localparam int MAXT = spt_pkg::MAX_TERMS;
  localparam int IW   = spt_pkg::IDX_W;
  localparam int CW   = spt_pkg::CNT_W;
  localparam int PW   = spt_pkg::POS_W;
  localparam int EW   = spt_pkg::EXP_W;
  localparam int KW   = spt_pkg::COEF_W;
  localparam int GS   = spt_pkg::GRP_SIZE;
  localparam int NG   = spt_pkg::NUM_GRP;

  // term table, index 0 oldest
  logic signed [KW-1:0] tcoef [MAXT];
  logic [EW-1:0]        texp  [MAXT];
  logic [CW-1:0]        count;

  // latched item
  logic [2:0]           op_mode;
  logic signed [15:0]   op_ca;
  logic [EW-1:0]        op_ea;
  logic signed [15:0]   op_cb;
  logic [EW-1:0]        op_eb;
  logic [4:0]           op_pos;

  // lookup results
  logic signed [KW-1:0] delta;
  logic [EW-1:0]        key;
  logic                 key_ovf;
  logic                 hit;
  logic [IW-1:0]        hit_idx;
  logic signed [KW-1:0] rd_coef;
  logic [EW-1:0]        rd_exp;
  logic                 pos_ok;

  // execute results
  logic signed [KW-1:0] res_coef;
  logic [EW-1:0]        res_exp;
  logic [2:0]           res_status;

  logic [EW-1:0]        deg_grp [NG];

  // ---------------- lookup ----------------
  logic [EW:0]          key_sum;
  logic [EW:0]          key_c;
  logic [MAXT-1:0]      match_vec;
  logic                 hit_c;
  logic [IW-1:0]        hit_idx_c;
  logic [PW-1:0]        pos_ext;
  logic [PW-1:0]        cnt_ext;
  logic [PW-1:0]        pos_k;
  logic [IW-1:0]        rd_idx;
  logic signed [KW-1:0] ca_ext;
  logic signed [KW-1:0] prod;
  logic signed [KW-1:0] delta_c;

  assign key_sum = {1'b0, op_ea} + {1'b0, op_eb};
  assign key_c   = (op_mode == spt_pkg::MODE_PROD) ? key_sum : {1'b0, op_ea};
  assign ca_ext  = {{(KW-16){op_ca[15]}}, op_ca};
  assign prod    = op_ca * op_cb;
  assign pos_ext = PW'(op_pos);
  assign cnt_ext = PW'(count);
  assign pos_k   = cnt_ext - pos_ext;

  always_comb begin
    hit_c     = 1'b0;
    hit_idx_c = '0;
    for (int i = 0; i < MAXT; i++) begin
      match_vec[i] = (CW'(i) < count) && (texp[i] == key_c[EW-1:0]);
    end
    for (int i = MAXT - 1; i >= 0; i--) begin
      if (match_vec[i]) begin
        hit_c     = 1'b1;
        hit_idx_c = IW'(i);
      end
    end
  end

  assign rd_idx = (op_mode == spt_pkg::MODE_RD_POS) ? pos_k[IW-1:0] : hit_idx_c;

  always_comb begin
    case (op_mode)
      spt_pkg::MODE_SUB:  delta_c = -ca_ext;
      spt_pkg::MODE_PROD: delta_c = prod;
      default:            delta_c = ca_ext;
    endcase
  end

  // ---------------- execute ----------------
  logic signed [KW:0]   sum;
  logic signed [KW-1:0] sat_c;
  logic                 wr_en;
  logic                 app_en;
  logic                 rm_en;
  logic [IW-1:0]        wr_idx;
  logic signed [KW-1:0] wr_coef;
  logic signed [KW-1:0] res_coef_c;
  logic [EW-1:0]        res_exp_c;
  logic [2:0]           res_status_c;
  logic                 full;

  assign sum  = {delta[KW-1], delta} + {rd_coef[KW-1], rd_coef};
  assign full = (count >= CW'(MAXT));

  always_comb begin
    if (sum[KW] != sum[KW-1]) begin
      sat_c = sum[KW] ? {1'b1, {(KW-1){1'b0}}} : {1'b0, {(KW-1){1'b1}}};
    end else begin
      sat_c = sum[KW-1:0];
    end
  end

  always_comb begin
    wr_en        = 1'b0;
    app_en       = 1'b0;
    rm_en        = 1'b0;
    wr_idx       = hit_idx;
    wr_coef      = sat_c;
    res_coef_c   = '0;
    res_exp_c    = '0;
    res_status_c = spt_pkg::STAT_OK;
    case (op_mode)
      spt_pkg::MODE_ADD, spt_pkg::MODE_SUB, spt_pkg::MODE_PROD: begin
        if (key_ovf) begin
          res_status_c = spt_pkg::STAT_EXP_OVF;
        end else begin
          res_exp_c = key;
          if (hit) begin
            if (sat_c == '0) begin
              rm_en = 1'b1;
            end else begin
              wr_en      = 1'b1;
              res_coef_c = sat_c;
            end
          end else if (delta == '0) begin
            res_status_c = spt_pkg::STAT_OK;
          end else if (full) begin
            res_status_c = spt_pkg::STAT_FULL;
          end else begin
            wr_en      = 1'b1;
            app_en     = 1'b1;
            wr_idx     = count[IW-1:0];
            wr_coef    = delta;
            res_coef_c = delta;
          end
        end
      end
      spt_pkg::MODE_SET: begin
        res_exp_c = key;
        wr_coef   = ca_ext;
        if (!hit) begin
          res_status_c = spt_pkg::STAT_NOT_FOUND;
        end else if (op_ca == '0) begin
          rm_en = 1'b1;
        end else begin
          wr_en      = 1'b1;
          res_coef_c = ca_ext;
        end
      end
      spt_pkg::MODE_RD_EXP: begin
        res_exp_c = key;
        if (!hit) begin
          res_status_c = spt_pkg::STAT_NOT_FOUND;
        end else begin
          res_coef_c = rd_coef;
        end
      end
      spt_pkg::MODE_RD_POS: begin
        if (count == '0) begin
          res_status_c = spt_pkg::STAT_EMPTY;
        end else if (!pos_ok) begin
          res_status_c = spt_pkg::STAT_NOT_FOUND;
        end else begin
          res_coef_c = rd_coef;
          res_exp_c  = rd_exp;
        end
      end
      default: begin
        res_status_c = spt_pkg::STAT_OK;
      end
    endcase
  end

  // ---------------- degree tree ----------------
  logic [EW-1:0] grp_max [NG];
  logic [EW-1:0] deg_c;

  // group maximum computed with a running value so that later taps compare
  // against earlier ones inside the same group
  always_comb begin
    for (int g = 0; g < NG; g++) begin
      grp_max[g] = '0;
      for (int j = 0; j < GS; j++) begin
        if ((g * GS + j < MAXT) && (CW'(g * GS + j) < count)) begin
          if (texp[(g * GS + j) % MAXT] > grp_max[g]) begin
            grp_max[g] = texp[(g * GS + j) % MAXT];
          end
        end
      end
    end
  end

  always_comb begin
    deg_c = '0;
    for (int g = 0; g < NG; g++) begin
      if (deg_grp[g] > deg_c) deg_c = deg_grp[g];
    end
  end

  // ---------------- registers ----------------
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      op_mode <= mode;
      op_ca   <= coef_a;
      op_ea   <= exp_a;
      op_cb   <= coef_b;
      op_eb   <= exp_b;
      op_pos  <= position;
    end
    if (cmd.look) begin
      delta   <= delta_c;
      key     <= key_c[EW-1:0];
      key_ovf <= (op_mode == spt_pkg::MODE_PROD) && key_c[EW];
      hit     <= hit_c;
      hit_idx <= hit_idx_c;
      rd_coef <= tcoef[rd_idx];
      rd_exp  <= texp[rd_idx];
      pos_ok  <= (pos_ext != '0) && (pos_ext <= cnt_ext);
    end
    if (cmd.exec) begin
      res_coef   <= res_coef_c;
      res_exp    <= res_exp_c;
      res_status <= res_status_c;
      if (rm_en) begin
        // close the gap: younger terms move down one place
        for (int i = 0; i < MAXT - 1; i++) begin
          if (IW'(i) >= hit_idx) begin
            tcoef[i] <= tcoef[i+1];
            texp[i]  <= texp[i+1];
          end
        end
      end
      if (wr_en) begin
        tcoef[wr_idx] <= wr_coef;
        texp[wr_idx]  <= key;
      end
    end
    if (cmd.deg) begin
      for (int g = 0; g < NG; g++) begin
        deg_grp[g] <= grp_max[g];
      end
    end
    if (cmd.load_out) begin
      coefficient <= res_coef;
      exponent    <= res_exp;
      term_count  <= 5'(count);
      degree      <= deg_c;
      status      <= res_status;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.exec) begin
        if (rm_en) begin
          count <= count - CW'(1);
        end else if (app_en) begin
          count <= count + CW'(1);
        end
      end
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign sts.out_free = !out_valid || out_ready;

endmodule

// ----- hdl/sparse_polynomial_term_table.sv -----
// ----------------------------------------------------------------------------
// sparse_polynomial_term_table: bounded table of polynomial terms
// Stores up to MAX_TERMS (coefficient, exponent) terms in insertion order and
// runs one add, subtract, product-add, set or read operation per item.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries one operation per item: mode,
//   coef_a, exp_a, coef_b, exp_b and position. Output channel
//   (out_valid/out_ready) returns exactly one result item per input item:
//   coefficient, exponent, term_count, degree and status.
//   The result is registered after lookup, execute, degree group stage and
//   result load, in that order. A new item is taken only after the last one
//   leaves the done state; in_ready is high only while the sequencer is idle.
//   Lookup compares all stored exponents in parallel; the degree is a
//   two-level maximum tree with one register level between the levels.
//   The result register frees the input side: a new item is accepted while
//   an earlier result still waits. When the receiver stalls, the finished
//   item waits in the sequencer's done state until the result register drains.
//   Reset (rst, synchronous) empties the table and drops any pending result;
//   term storage is not cleared, only the count, since unused entries are
//   never read.
// ----------------------------------------------------------------------------
module sparse_polynomial_term_table (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [2:0]         mode,
  input  logic signed [15:0] coef_a,
  input  logic [9:0]         exp_a,
  input  logic signed [15:0] coef_b,
  input  logic [9:0]         exp_b,
  input  logic [4:0]         position,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] coefficient,
  output logic [9:0]         exponent,
  output logic [4:0]         term_count,
  output logic [9:0]         degree,
  output logic [2:0]         status
);

  spt_pkg::cmd_t cmd;
  spt_pkg::sts_t sts;

  // sequence each item through the datapath
  spt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // hold the table and compute the result
  spt_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .sts         (sts),
    .mode        (mode),
    .coef_a      (coef_a),
    .exp_a       (exp_a),
    .coef_b      (coef_b),
    .exp_b       (exp_b),
    .position    (position),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .coefficient (coefficient),
    .exponent    (exponent),
    .term_count  (term_count),
    .degree      (degree),
    .status      (status)
  );

  // an accepted item blocks the input until its result is loaded
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input accepted while an item is in flight");

  // an empty table reports degree zero
  a_empty_degree: assert property (@(posedge clk) disable iff (rst)
    (out_valid && term_count == '0) |-> (degree == '0))
    else $error("nonzero degree with empty table");

  // empty-table status carries no term
  a_empty_status: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == spt_pkg::STAT_EMPTY) |->
      (term_count == '0 && coefficient == '0 && exponent == '0))
    else $error("empty status with stored terms or a term value");

  // a full report only comes with the table at its limit
  a_full_count: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == spt_pkg::STAT_FULL) |->
      (term_count == 5'(spt_pkg::MAX_TERMS) && coefficient == '0))
    else $error("full status below table capacity");

endmodule
